>>> sv/rstk_pkg.sv
`timescale 1ns / 1ps

package rstk_pkg;

  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned MIN_CAP_DEF = 5;
  localparam int unsigned INIT_CAP    = 10;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FIELD_W = 11;

  // capacity / 5 as (capacity * FIFTH_MULT) >> FIFTH_SHIFT, exact below 2**22
  localparam int unsigned FIFTH_MULT  = 3355444;
  localparam int unsigned FIFTH_SHIFT = 24;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RS_NONE   = 2'd0,
    RS_GREW   = 2'd1,
    RS_SHRANK = 2'd2
  } resize_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

>>> sv/rstk_if.sv
`timescale 1ns / 1ps

interface rstk_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [rstk_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface rstk_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rstk_pkg::WORD_W-1:0]  pop_value;
  logic [1:0]                          status;
  logic [rstk_pkg::FIELD_W-1:0]        entry_count;
  logic [rstk_pkg::FIELD_W-1:0]        capacity;
  logic [rstk_pkg::FIELD_W-1:0]        largest_capacity;
  logic [1:0]                          resized;

  modport source (output valid, pop_value, status, entry_count, capacity,
                  largest_capacity, resized, input ready);
  modport sink   (input valid, pop_value, status, entry_count, capacity,
                  largest_capacity, resized, output ready);
endinterface

>>> sv/rstk_mem.sv
`timescale 1ns / 1ps

module rstk_mem #(
  parameter int unsigned DEPTH = rstk_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  rstk_pkg::mem_ctrl_t           mem_ctrl_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [rstk_pkg::WORD_W-1:0]   wdata_i,
  output logic [rstk_pkg::WORD_W-1:0]   rdata_o
);

  logic [rstk_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [rstk_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rstk_ctrl.sv
`timescale 1ns / 1ps

module rstk_ctrl #(
  parameter int unsigned DEPTH        = rstk_pkg::DEPTH_DEF,
  parameter int unsigned MIN_CAPACITY = rstk_pkg::MIN_CAP_DEF,
  localparam int unsigned AW          = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rstk_pkg::FIELD_W-1:0]  cfg_wdata_i,
  rstk_req_if.sink                      req_i,
  rstk_rsp_if.source                    rsp_o,
  output rstk_pkg::mem_ctrl_t           mem_ctrl_o,
  output logic [AW-1:0]                 mem_addr_o,
  output logic [rstk_pkg::WORD_W-1:0]   mem_wdata_o,
  input  logic [rstk_pkg::WORD_W-1:0]   mem_rdata_i
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned VW    = (CW > rstk_pkg::FIELD_W) ? CW : rstk_pkg::FIELD_W;
  localparam int unsigned PW    = CW + rstk_pkg::FIFTH_SHIFT;
  localparam int unsigned FLOOR = (MIN_CAPACITY < DEPTH) ? MIN_CAPACITY : DEPTH;
  localparam int unsigned RST_CAP = (rstk_pkg::INIT_CAP < FLOOR) ? FLOOR :
                                    (rstk_pkg::INIT_CAP > DEPTH) ? DEPTH :
                                    rstk_pkg::INIT_CAP;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       cap_q, cap_d;
  logic [CW-1:0]       largest_q, largest_d;
  logic                enl_q, enl_d;
  logic                out_valid_q, out_valid_d;
  logic                pop_ok_q, pop_ok_d;
  rstk_pkg::status_e   status_q, status_d;
  rstk_pkg::resize_e   resized_q, resized_d;

  logic                fire;
  logic                is_pop;
  logic                do_resize;
  logic [PW-1:0]       fifth_prod;
  logic [CW-1:0]       fifth;
  logic [CW-1:0]       half;
  logic [CW-1:0]       shrunk;
  logic [CW:0]         grown_w;
  logic [CW-1:0]       grown;
  logic                shrink_hit;
  logic                grow_hit;
  logic [VW-1:0]       cfg_ext;
  logic [CW-1:0]       cfg_cap;
  logic [VW-1:0]       count_ext;
  logic [VW-1:0]       cap_ext;
  logic [VW-1:0]       largest_ext;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign is_pop      = (req_i.req_type == rstk_pkg::REQ_POP);

  assign fifth_prod = PW'(cap_q) * PW'(rstk_pkg::FIFTH_MULT);
  assign fifth      = fifth_prod[rstk_pkg::FIFTH_SHIFT +: CW];

  assign half    = cap_q >> 1;
  assign shrunk  = (half <= CW'(FLOOR)) ? CW'(FLOOR) : half;
  assign grown_w = {1'b0, cap_q} + {2'b00, cap_q[CW-1:1]};
  assign grown   = (grown_w > (CW+1)'(DEPTH)) ? CW'(DEPTH) : grown_w[CW-1:0];

  assign shrink_hit = is_pop && enl_q &&
                      (({1'b0, fifth} + (CW+1)'(1)) >= {1'b0, count_d});
  assign grow_hit   = (({1'b0, cap_q} - {1'b0, fifth} + (CW+1)'(1)) <= {1'b0, count_d});

  assign cfg_ext = VW'(cfg_wdata_i);
  always_comb begin
    priority if (cfg_ext < VW'(FLOOR)) begin
      cfg_cap = CW'(FLOOR);
    end else if (cfg_ext > VW'(DEPTH)) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = cfg_ext[CW-1:0];
    end
  end

  always_comb begin
    count_d    = count_q;
    mem_ctrl_o = '0;
    mem_addr_o = count_q[AW-1:0];
    status_d   = rstk_pkg::ST_OK;
    do_resize  = 1'b0;
    pop_ok_d   = 1'b0;
    unique case (req_i.req_type)
      rstk_pkg::REQ_PUSH: begin
        if (count_q == CW'(DEPTH)) begin
          status_d = rstk_pkg::ST_FULL;
        end else begin
          mem_ctrl_o.wr_en = fire;
          count_d          = count_q + CW'(1);
          do_resize        = 1'b1;
        end
      end
      rstk_pkg::REQ_POP: begin
        if (count_q == '0) begin
          status_d = rstk_pkg::ST_EMPTY;
        end else begin
          count_d          = count_q - CW'(1);
          mem_addr_o       = count_d[AW-1:0];
          mem_ctrl_o.rd_en = fire;
          pop_ok_d         = 1'b1;
          do_resize        = 1'b1;
        end
      end
      default: begin
        status_d = rstk_pkg::ST_OK;
      end
    endcase
  end

  assign mem_wdata_o = req_i.push_value;

  always_comb begin
    cap_d     = cap_q;
    largest_d = largest_q;
    enl_d     = enl_q;
    resized_d = rstk_pkg::RS_NONE;
    if (do_resize) begin
      priority if (shrink_hit) begin
        cap_d = shrunk;
        if (shrunk != cap_q) begin
          resized_d = rstk_pkg::RS_SHRANK;
        end
      end else if (grow_hit) begin
        cap_d = grown;
        enl_d = 1'b1;
        if (grown > largest_q) begin
          largest_d = grown;
        end
        if (grown != cap_q) begin
          resized_d = rstk_pkg::RS_GREW;
        end
      end else begin
        cap_d = cap_q;
      end
    end
  end

  assign out_valid_d = fire || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CW'(RST_CAP);
      largest_q   <= CW'(RST_CAP);
      enl_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pop_ok_q    <= 1'b0;
      status_q    <= rstk_pkg::ST_OK;
      resized_q   <= rstk_pkg::RS_NONE;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q   <= '0;
        cap_q     <= cfg_cap;
        largest_q <= cfg_cap;
        enl_q     <= 1'b0;
      end else if (fire) begin
        count_q   <= count_d;
        cap_q     <= cap_d;
        largest_q <= largest_d;
        enl_q     <= enl_d;
        pop_ok_q  <= pop_ok_d;
        status_q  <= status_d;
        resized_q <= resized_d;
      end
    end
  end

  assign count_ext   = VW'(count_q);
  assign cap_ext     = VW'(cap_q);
  assign largest_ext = VW'(largest_q);

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.pop_value        = pop_ok_q ? mem_rdata_i : '0;
  assign rsp_o.status           = status_q;
  assign rsp_o.entry_count      = count_ext[rstk_pkg::FIELD_W-1:0];
  assign rsp_o.capacity         = cap_ext[rstk_pkg::FIELD_W-1:0];
  assign rsp_o.largest_capacity = largest_ext[rstk_pkg::FIELD_W-1:0];
  assign rsp_o.resized          = resized_q;

endmodule

>>> sv/resizing_stack_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake      payload
// req_i     in         valid / ready  req_type, push_value
// rsp_o     out        valid / ready  pop_value, status, entry_count, capacity,
//                                     largest_capacity, resized
// cfg       in         cfg_we_i       cfg_wdata_i (initial capacity)
//
// One request per cycle while rsp_o is not stalled; its response is valid the cycle after acceptance.
// A pop reads the stack memory at acceptance; the registered read data of the
// single-port memory sets the response timing, while count and capacity update at once.
// req_i.ready is low only while a response waits on a stalled rsp_o.
// Reset clears the count and loads the capacity with 10, clamped to
// [MIN_CAPACITY, DEPTH]; the memory itself is not cleared.

module resizing_stack_top #(
  parameter int unsigned DEPTH        = rstk_pkg::DEPTH_DEF,
  parameter int unsigned MIN_CAPACITY = rstk_pkg::MIN_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rstk_pkg::FIELD_W-1:0]  cfg_wdata_i,
  rstk_req_if.sink                      req_i,
  rstk_rsp_if.source                    rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  rstk_pkg::mem_ctrl_t          mem_ctrl;
  logic [AW-1:0]                mem_addr;
  logic [rstk_pkg::WORD_W-1:0]  mem_wdata;
  logic [rstk_pkg::WORD_W-1:0]  mem_rdata;

  rstk_ctrl #(
    .DEPTH        (DEPTH),
    .MIN_CAPACITY (MIN_CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_ctrl_o  (mem_ctrl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  rstk_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i      (clk_i),
    .mem_ctrl_i (mem_ctrl),
    .addr_i     (mem_addr),
    .wdata_i    (mem_wdata),
    .rdata_o    (mem_rdata)
  );

endmodule
